// ===== design/vpcc_pkg.sv =====
`timescale 1ns / 1ps

package vpcc_pkg;

    // Access kinds carried by an input item.
    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_RAISE = 2'd2
    } op_t;

    // Per-queue state, kept as one memory row per queue.
    typedef struct packed {
        logic [15:0]      size;
        logic [15:0]      vector;
        logic             enabled;
        logic [5:0][31:0] ring;
    } queue_row_t;

    localparam int VERSION_BIT = 32;

    // Common configuration offsets.
    localparam logic [7:0] OFF_DEV_FEAT_SEL = 8'd0;
    localparam logic [7:0] OFF_DEV_FEAT     = 8'd4;
    localparam logic [7:0] OFF_DRV_FEAT_SEL = 8'd8;
    localparam logic [7:0] OFF_DRV_FEAT     = 8'd12;
    localparam logic [7:0] OFF_CFG_VECTOR   = 8'd16;
    localparam logic [7:0] OFF_NUM_QUEUES   = 8'd18;
    localparam logic [7:0] OFF_STATUS       = 8'd20;
    localparam logic [7:0] OFF_CFG_GEN      = 8'd21;
    localparam logic [7:0] OFF_QUEUE_SEL    = 8'd22;
    localparam logic [7:0] OFF_QUEUE_SIZE   = 8'd24;
    localparam logic [7:0] OFF_QUEUE_VECTOR = 8'd26;
    localparam logic [7:0] OFF_QUEUE_ENABLE = 8'd28;
    localparam logic [7:0] OFF_QUEUE_NOTIFY = 8'd30;
    localparam logic [7:0] OFF_RING_0       = 8'd32;
    localparam logic [7:0] OFF_RING_1       = 8'd36;
    localparam logic [7:0] OFF_RING_2       = 8'd40;
    localparam logic [7:0] OFF_RING_3       = 8'd44;
    localparam logic [7:0] OFF_RING_4       = 8'd48;
    localparam logic [7:0] OFF_RING_5       = 8'd52;
    localparam logic [7:0] OFF_DOORBELL     = 8'd56;
    localparam logic [7:0] OFF_ISR          = 8'd60;
    localparam logic [7:0] OFF_DEVICE       = 8'd64;

    // Base of the ring words, in 32-bit word units.
    localparam logic [3:0] RING_WORD_BASE = 4'd8;

endpackage

// ===== design/virtio_pci_common_config_regs.sv =====
`timescale 1ns / 1ps

// Register window of a virtio 1.x PCI transport (modern common configuration).
// Input channel: the bus side presents operation, offset and write_data with
// start high; the item is taken at a rising edge where start is high and busy
// is low. busy is never raised, so one item can be taken on every cycle.
// Output channel: done is high for exactly one cycle with the result fields
// valid beside it; the receiver cannot hold results off, so it must sample
// them in that cycle. status_value and negotiated_features show the state
// left by that item.
// From acceptance to done, the item is captured in an input register,
// decoded and applied in the next cycle, and the outcome is held in a result
// register. Throughput is one item per cycle, set by the single
// read-modify-write of the per-queue memory row.
// The per-queue state lives in a memory of one row per queue; a row valid
// bit per queue makes unwritten rows read as zero, so no clearing pass is
// needed and the block is ready straight after reset.
// Configuration (host_features at byte 0, queue_count at byte 8) is to be
// written over the APB-style port while the block is idle; the block itself
// does not enforce this. Reset clears all control state, the features
// offered, the ISR and the device status, and sets the queue count to one.
module virtio_pci_common_config_regs
    import vpcc_pkg::*;
#(
    parameter int MAX_QUEUES = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic [7:0]  offset,
    input  logic [31:0] write_data,

    output logic        done,
    output logic [31:0] read_data,
    output logic        access_ok,
    output logic        notify_valid,
    output logic [15:0] notify_queue,
    output logic        irq_lower,
    output logic        status_update,
    output logic [7:0]  status_value,
    output logic        device_region,
    output logic [63:0] negotiated_features,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int QSW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;

    // Configuration registers.
    logic [63:0] host_features_reg;
    logic [4:0]  queue_count_reg;

    // Input register.
    logic        in_valid_reg;
    op_t         op_reg;
    logic [7:0]  offset_reg;
    logic [31:0] wdata_reg;

    // Transport state.
    logic [31:0]    dev_sel_reg,  dev_sel_next;
    logic [31:0]    drv_sel_reg,  drv_sel_next;
    logic [63:0]    guest_reg,    guest_next;
    logic [7:0]     status_reg,   status_next;
    logic [15:0]    cfg_vec_reg,  cfg_vec_next;
    logic [QSW-1:0] qsel_reg,     qsel_next;
    logic [7:0]     isr_reg,      isr_next;

    // Per-queue memory, its row valid bits and the forwarding path.
    queue_row_t             row_mem [MAX_QUEUES];
    queue_row_t             mem_rd_reg;
    queue_row_t             byp_row_reg;
    logic                   byp_hit_reg;
    logic                   rd_valid_reg;
    logic [MAX_QUEUES-1:0]  row_valid_reg;
    queue_row_t             cur_row;
    queue_row_t             row_next;
    logic                   row_wr;

    // Result register.
    logic        done_reg;
    logic [31:0] rd_reg,     rd_next;
    logic        ok_reg,     ok_next;
    logic        nv_reg,     nv_next;
    logic [15:0] nq_reg,     nq_next;
    logic        lower_reg,  lower_next;
    logic        su_reg,     su_next;
    logic        dev_reg,    dev_next;

    logic        cfg_wr;
    logic        accept;
    logic [63:0] feats;
    logic [2:0]  ring_idx;
    logic [15:0] sel_value;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign pready = 1'b1;

    // Configuration port: bit 3 of the address picks the register.
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = paddr[3] ? {59'd0, queue_count_reg} : host_features_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            host_features_reg <= '0;
            queue_count_reg   <= 5'd1;
        end
        else if (cfg_wr)
        begin
            if (paddr[3])
            begin
                queue_count_reg <= pwdata[4:0];
            end
            else
            begin
                host_features_reg <= pwdata;
            end
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= op_t'(operation);
            offset_reg <= offset;
            wdata_reg  <= write_data;
        end
    end

    // The row of the selected queue. When the row being written is also the
    // one read for the next item, the written value is forwarded.
    assign cur_row = byp_hit_reg  ? byp_row_reg :
                     rd_valid_reg ? mem_rd_reg  : '0;

    assign feats     = host_features_reg | (64'd1 << VERSION_BIT);
    assign ring_idx  = 3'(offset_reg[5:2] - RING_WORD_BASE);
    assign sel_value = wdata_reg[15:0];

    always_comb
    begin
        dev_sel_next = dev_sel_reg;
        drv_sel_next = drv_sel_reg;
        guest_next   = guest_reg;
        status_next  = status_reg;
        cfg_vec_next = cfg_vec_reg;
        qsel_next    = qsel_reg;
        isr_next     = isr_reg;
        row_next     = cur_row;
        row_wr       = 1'b0;
        rd_next      = '0;
        ok_next      = 1'b0;
        nv_next      = 1'b0;
        nq_next      = '0;
        lower_next   = 1'b0;
        su_next      = 1'b0;
        dev_next     = 1'b0;

        if (in_valid_reg)
        begin
            case (op_reg)
                OP_RAISE:
                begin
                    isr_next = isr_reg | wdata_reg[7:0];
                    ok_next  = 1'b1;
                end
                OP_READ, OP_WRITE:
                begin
                    if (offset_reg < OFF_DOORBELL)
                    begin
                        ok_next = 1'b1;
                        if (op_reg == OP_WRITE)
                        begin
                            case (offset_reg)
                                OFF_DEV_FEAT_SEL: dev_sel_next = wdata_reg;
                                OFF_DRV_FEAT_SEL: drv_sel_next = wdata_reg;
                                OFF_DRV_FEAT:
                                begin
                                    if (drv_sel_reg == 32'd0)
                                    begin
                                        guest_next[31:0] = guest_reg[31:0] | wdata_reg;
                                    end
                                    else if (drv_sel_reg == 32'd1)
                                    begin
                                        guest_next[63:32] = guest_reg[63:32] | wdata_reg;
                                    end
                                end
                                OFF_CFG_VECTOR: cfg_vec_next = wdata_reg[15:0];
                                OFF_STATUS:
                                begin
                                    status_next = wdata_reg[7:0];
                                    su_next     = 1'b1;
                                end
                                OFF_QUEUE_SEL:
                                begin
                                    if ((sel_value < {11'd0, queue_count_reg}) &&
                                        (sel_value < 16'(MAX_QUEUES)))
                                    begin
                                        qsel_next = sel_value[QSW-1:0];
                                    end
                                end
                                OFF_QUEUE_SIZE:
                                begin
                                    row_next.size = wdata_reg[15:0];
                                    row_wr        = 1'b1;
                                end
                                OFF_QUEUE_VECTOR:
                                begin
                                    row_next.vector = wdata_reg[15:0];
                                    row_wr          = 1'b1;
                                end
                                OFF_QUEUE_ENABLE:
                                begin
                                    row_next.enabled = |wdata_reg[15:0];
                                    row_wr           = 1'b1;
                                end
                                OFF_RING_0, OFF_RING_1, OFF_RING_2,
                                OFF_RING_3, OFF_RING_4, OFF_RING_5:
                                begin
                                    row_next.ring[ring_idx] = wdata_reg;
                                    row_wr                  = 1'b1;
                                end
                                default: ;
                            endcase
                        end
                        else
                        begin
                            case (offset_reg)
                                OFF_DEV_FEAT_SEL: rd_next = dev_sel_reg;
                                OFF_DEV_FEAT:
                                begin
                                    if (dev_sel_reg == 32'd0)
                                    begin
                                        rd_next = feats[31:0];
                                    end
                                    else if (dev_sel_reg == 32'd1)
                                    begin
                                        rd_next = feats[63:32];
                                    end
                                end
                                OFF_DRV_FEAT_SEL: rd_next = drv_sel_reg;
                                OFF_CFG_VECTOR:   rd_next = {16'd0, cfg_vec_reg};
                                OFF_NUM_QUEUES:   rd_next = {27'd0, queue_count_reg};
                                OFF_STATUS:       rd_next = {24'd0, status_reg};
                                OFF_CFG_GEN:      rd_next = '0;
                                OFF_QUEUE_SEL, OFF_QUEUE_NOTIFY:
                                    rd_next = {{(32-QSW){1'b0}}, qsel_reg};
                                OFF_QUEUE_SIZE:   rd_next = {16'd0, cur_row.size};
                                OFF_QUEUE_VECTOR: rd_next = {16'd0, cur_row.vector};
                                OFF_QUEUE_ENABLE: rd_next = {31'd0, cur_row.enabled};
                                OFF_RING_0, OFF_RING_1, OFF_RING_2,
                                OFF_RING_3, OFF_RING_4, OFF_RING_5:
                                    rd_next = cur_row.ring[ring_idx];
                                default:          rd_next = '0;
                            endcase
                        end
                    end
                    else if (offset_reg < OFF_ISR)
                    begin
                        // Doorbell: only a write has a handler.
                        if (op_reg == OP_WRITE)
                        begin
                            ok_next = 1'b1;
                            nv_next = 1'b1;
                            nq_next = wdata_reg[15:0];
                        end
                    end
                    else if (offset_reg < OFF_DEVICE)
                    begin
                        // ISR: read-to-clear, and only at its first byte.
                        if ((op_reg == OP_READ) && (offset_reg == OFF_ISR))
                        begin
                            ok_next    = 1'b1;
                            rd_next    = {24'd0, isr_reg};
                            isr_next   = '0;
                            lower_next = 1'b1;
                        end
                    end
                    else
                    begin
                        ok_next  = 1'b1;
                        dev_next = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // State and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_sel_reg   <= '0;
            drv_sel_reg   <= '0;
            guest_reg     <= '0;
            status_reg    <= '0;
            cfg_vec_reg   <= '0;
            qsel_reg      <= '0;
            isr_reg       <= '0;
            row_valid_reg <= '0;
            byp_hit_reg   <= 1'b0;
            rd_valid_reg  <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            dev_sel_reg  <= dev_sel_next;
            drv_sel_reg  <= drv_sel_next;
            guest_reg    <= guest_next;
            status_reg   <= status_next;
            cfg_vec_reg  <= cfg_vec_next;
            qsel_reg     <= qsel_next;
            isr_reg      <= isr_next;
            if (row_wr)
            begin
                row_valid_reg[qsel_reg] <= 1'b1;
            end
            byp_hit_reg  <= row_wr && (qsel_reg == qsel_next);
            rd_valid_reg <= row_valid_reg[qsel_next];
            done_reg     <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg    <= rd_next;
        ok_reg    <= ok_next;
        nv_reg    <= nv_next;
        nq_reg    <= nq_next;
        lower_reg <= lower_next;
        su_reg    <= su_next;
        dev_reg   <= dev_next;
    end

    // Per-queue memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (row_wr)
        begin
            row_mem[qsel_reg] <= row_next;
        end
        mem_rd_reg  <= row_mem[qsel_next];
        byp_row_reg <= row_next;
    end

    assign done                = done_reg;
    assign read_data           = rd_reg;
    assign access_ok           = ok_reg;
    assign notify_valid        = nv_reg;
    assign notify_queue        = nq_reg;
    assign irq_lower           = lower_reg;
    assign status_update       = su_reg;
    assign status_value        = status_reg;
    assign device_region       = dev_reg;
    assign negotiated_features = guest_reg;

endmodule

// ===== bench/tb_vpcc_pkg.sv =====
`timescale 1ns / 1ps

package tb_vpcc_pkg;

    // APB byte addresses of the configuration registers. host_features is 64 bits wide,
    // so the registers sit on 8-byte boundaries.
    localparam logic [3:0] ADDR_HOST_FEATURES = 4'd0;
    localparam logic [3:0] ADDR_QUEUE_COUNT   = 4'd8;

    // The one operation code that the block leaves unused.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Everything the block reports for one item.
    typedef struct packed {
        logic [31:0] read_data;
        logic        access_ok;
        logic        notify_valid;
        logic [15:0] notify_queue;
        logic        irq_lower;
        logic        status_update;
        logic [7:0]  status_value;
        logic        device_region;
        logic [63:0] negotiated_features;
    } access_result_t;

endpackage

// ===== bench/vpcc_result_checker.sv =====
`timescale 1ns / 1ps

module vpcc_result_checker
    import vpcc_pkg::*;
    import tb_vpcc_pkg::*;
#(
    parameter int MAX_QUEUES = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  operation,
    input  logic [7:0]  offset,
    input  logic [31:0] write_data,

    input  logic        done,
    input  logic [31:0] read_data,
    input  logic        access_ok,
    input  logic        notify_valid,
    input  logic [15:0] notify_queue,
    input  logic        irq_lower,
    input  logic        status_update,
    input  logic [7:0]  status_value,
    input  logic        device_region,
    input  logic [63:0] negotiated_features,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        pready,

    output int          fail_count,
    output int          outstanding,
    output int          checked_count
);

    localparam int RING_WORDS = 6;

    // Shadow of the configuration and of the register window.
    logic [63:0] host_features;
    logic [4:0]  queue_count;
    logic [31:0] dev_feat_sel;
    logic [31:0] drv_feat_sel;
    logic [63:0] guest_features;
    logic [7:0]  dev_status;
    logic [15:0] cfg_vector;
    logic [3:0]  q_sel;
    logic [15:0] q_vector [MAX_QUEUES];
    logic [15:0] q_size [MAX_QUEUES];
    logic        q_enabled [MAX_QUEUES];
    logic [31:0] ring_addr [MAX_QUEUES * RING_WORDS];
    logic [7:0]  isr_bits;

    access_result_t pending_results[$];
    int failures;
    int checked;

    assign fail_count    = failures;
    assign checked_count = checked;

    task automatic clear_window();
        host_features  = '0;
        queue_count    = 5'd1;
        dev_feat_sel   = '0;
        drv_feat_sel   = '0;
        guest_features = '0;
        dev_status     = '0;
        cfg_vector     = '0;
        q_sel          = '0;
        isr_bits       = '0;
        for (int i = 0; i < MAX_QUEUES; i++)
        begin
            q_vector[i]  = '0;
            q_size[i]    = '0;
            q_enabled[i] = 1'b0;
        end
        for (int i = 0; i < MAX_QUEUES * RING_WORDS; i++)
        begin
            ring_addr[i] = '0;
        end
    endtask

    function automatic int ring_slot(logic [7:0] off);
        return int'(q_sel) * RING_WORDS + int'((off - OFF_RING_0) >> 2);
    endfunction

    function automatic logic [31:0] read_common(logic [7:0] off);
        logic [63:0] offered;
        offered = host_features | (64'd1 << VERSION_BIT);
        case (off)
            OFF_DEV_FEAT_SEL: return dev_feat_sel;
            OFF_DEV_FEAT:
            begin
                if (dev_feat_sel > 32'd1)
                    return '0;
                return dev_feat_sel[0] ? offered[63:32] : offered[31:0];
            end
            OFF_DRV_FEAT_SEL: return drv_feat_sel;
            OFF_CFG_VECTOR:   return {16'd0, cfg_vector};
            OFF_NUM_QUEUES:   return {27'd0, queue_count};
            OFF_STATUS:       return {24'd0, dev_status};
            OFF_CFG_GEN:      return '0;
            OFF_QUEUE_SEL,
            OFF_QUEUE_NOTIFY: return {28'd0, q_sel};
            OFF_QUEUE_SIZE:   return {16'd0, q_size[q_sel]};
            OFF_QUEUE_VECTOR: return {16'd0, q_vector[q_sel]};
            OFF_QUEUE_ENABLE: return {31'd0, q_enabled[q_sel]};
            OFF_RING_0, OFF_RING_1, OFF_RING_2,
            OFF_RING_3, OFF_RING_4, OFF_RING_5:
                return ring_addr[ring_slot(off)];
            default:          return '0;
        endcase
    endfunction

    // Returns 1 when the status byte was written.
    function automatic logic write_common(logic [7:0] off, logic [31:0] v);
        case (off)
            OFF_DEV_FEAT_SEL: dev_feat_sel = v;
            OFF_DRV_FEAT_SEL: drv_feat_sel = v;
            OFF_DRV_FEAT:
            begin
                if (drv_feat_sel <= 32'd1)
                    guest_features |= {32'd0, v} << (drv_feat_sel[0] ? 32 : 0);
            end
            OFF_CFG_VECTOR:   cfg_vector = v[15:0];
            OFF_STATUS:
            begin
                dev_status = v[7:0];
                return 1'b1;
            end
            OFF_QUEUE_SEL:
            begin
                if (v[15:0] < {11'd0, queue_count} && v[15:0] < MAX_QUEUES)
                    q_sel = v[3:0];
            end
            OFF_QUEUE_SIZE:   q_size[q_sel] = v[15:0];
            OFF_QUEUE_VECTOR: q_vector[q_sel] = v[15:0];
            OFF_QUEUE_ENABLE: q_enabled[q_sel] = |v[15:0];
            OFF_RING_0, OFF_RING_1, OFF_RING_2,
            OFF_RING_3, OFF_RING_4, OFF_RING_5:
                ring_addr[ring_slot(off)] = v;
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic access_result_t predict_access(logic [1:0] op, logic [7:0] off,
                                                      logic [31:0] data);
        access_result_t r;
        r = '0;
        case (op)
            OP_RAISE:
            begin
                isr_bits   |= data[7:0];
                r.access_ok = 1'b1;
            end
            OP_READ, OP_WRITE:
            begin
                if (off < OFF_DOORBELL)
                begin
                    r.access_ok = 1'b1;
                    if (op == OP_WRITE)
                        r.status_update = write_common(off, data);
                    else
                        r.read_data = read_common(off);
                end
                else if (off < OFF_ISR)
                begin
                    if (op == OP_WRITE)
                    begin
                        r.access_ok    = 1'b1;
                        r.notify_valid = 1'b1;
                        r.notify_queue = data[15:0];
                    end
                end
                else if (off < OFF_DEVICE)
                begin
                    if (op == OP_READ && off == OFF_ISR)
                    begin
                        r.access_ok = 1'b1;
                        r.read_data = {24'd0, isr_bits};
                        r.irq_lower = 1'b1;
                        isr_bits    = '0;
                    end
                end
                else
                begin
                    r.access_ok     = 1'b1;
                    r.device_region = 1'b1;
                end
            end
            default: ;
        endcase
        r.status_value        = dev_status;
        r.negotiated_features = guest_features;
        return r;
    endfunction

    task automatic note_field(input string name, input logic [63:0] want,
                              input logic [63:0] got, inout bit bad);
        if (want !== got)
        begin
            if (failures < 10)
                $display("%0t: result %0d, %s: expected %h, got %h",
                         $realtime, checked, name, want, got);
            bad = 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        access_result_t want;
        bit bad;
        if (!rst_n)
        begin
            clear_window();
            pending_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    if (failures < 10)
                        $display("%0t: result arrived with nothing expected", $realtime);
                    failures++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    bad  = 1'b0;
                    note_field("read_data", 64'(want.read_data), 64'(read_data), bad);
                    note_field("access_ok", 64'(want.access_ok), 64'(access_ok), bad);
                    note_field("notify_valid", 64'(want.notify_valid),
                               64'(notify_valid), bad);
                    note_field("notify_queue", 64'(want.notify_queue),
                               64'(notify_queue), bad);
                    note_field("irq_lower", 64'(want.irq_lower), 64'(irq_lower), bad);
                    note_field("status_update", 64'(want.status_update),
                               64'(status_update), bad);
                    note_field("status_value", 64'(want.status_value),
                               64'(status_value), bad);
                    note_field("device_region", 64'(want.device_region),
                               64'(device_region), bad);
                    note_field("negotiated_features", want.negotiated_features,
                               negotiated_features, bad);
                    if (bad)
                        failures++;
                    checked++;
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == ADDR_HOST_FEATURES)
                    host_features = pwdata;
                else if (paddr == ADDR_QUEUE_COUNT)
                    queue_count = pwdata[4:0];
            end
            if (start && !busy)
                pending_results.push_back(predict_access(operation, offset, write_data));
            outstanding <= pending_results.size();
        end
    end

endmodule

// ===== bench/tb_virtio_pci_common_config_regs.sv =====
`timescale 1ns / 1ps

// Top of the bench. It makes the clock and the single reset, drives register
// accesses into the block and writes its two configuration registers over the
// APB port. All prediction and comparison happen in the checker, which sits
// beside the block and watches the same wires; this module only decides the
// verdict from the failure count and the number of results still owed.
module tb_virtio_pci_common_config_regs;
    import vpcc_pkg::*;
    import tb_vpcc_pkg::*;

    localparam int QUEUE_SLOTS   = 16;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_ITEMS   = 190;
    // Cycles of margin allowed, once every result is out, before the
    // configuration is touched.
    localparam int SETTLE_CYCLES = 6;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  operation = '0;
    logic [7:0]  offset = '0;
    logic [31:0] write_data = '0;

    logic        done;
    logic [31:0] read_data;
    logic        access_ok;
    logic        notify_valid;
    logic [15:0] notify_queue;
    logic        irq_lower;
    logic        status_update;
    logic [7:0]  status_value;
    logic        device_region;
    logic [63:0] negotiated_features;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    int fail_count;
    int outstanding;
    int checked_count;

    // Stimulus bookkeeping.
    int items_sent;
    int gap_mode;
    int settings_used;
    logic [4:0] cur_queue_count = 5'd1;

    always #5 clk = ~clk;

    virtio_pci_common_config_regs #(
        .MAX_QUEUES(QUEUE_SLOTS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .operation(operation),
        .offset(offset),
        .write_data(write_data),
        .done(done),
        .read_data(read_data),
        .access_ok(access_ok),
        .notify_valid(notify_valid),
        .notify_queue(notify_queue),
        .irq_lower(irq_lower),
        .status_update(status_update),
        .status_value(status_value),
        .device_region(device_region),
        .negotiated_features(negotiated_features),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    vpcc_result_checker #(
        .MAX_QUEUES(QUEUE_SLOTS)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .operation(operation),
        .offset(offset),
        .write_data(write_data),
        .done(done),
        .read_data(read_data),
        .access_ok(access_ok),
        .notify_valid(notify_valid),
        .notify_queue(notify_queue),
        .irq_lower(irq_lower),
        .status_update(status_update),
        .status_value(status_value),
        .device_region(device_region),
        .negotiated_features(negotiated_features),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .pready(pready),
        .fail_count(fail_count),
        .outstanding(outstanding),
        .checked_count(checked_count)
    );

    // Gap before an item. Mode 0 keeps start high back to back, mode 1 adds
    // short pauses now and then, mode 2 mixes short pauses with a few long
    // ones so that gaps land on every stage of the pipeline.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        case (gap_mode)
            0:       return 0;
            1:       return (roll < 70) ? 0 : $urandom_range(1, 3);
            default:
            begin
                if (roll < 50)
                    return 0;
                if (roll < 85)
                    return $urandom_range(1, 4);
                return $urandom_range(5, 30);
            end
        endcase
    endfunction

    // Presents one item and returns at the edge that takes it. start is left
    // high so that a following item can go out on the very next cycle; it is
    // only lowered when a gap is wanted, which keeps a single assignment to
    // start in any one time step.
    task automatic send_item(input logic [1:0] op, input logic [7:0] off,
                             input logic [31:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        operation  <= op;
        offset     <= off;
        write_data <= data;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
    endtask

    // Holds the sender back until every result owed has come out, then lets
    // the pipeline settle. The first edge lets the checker count the item
    // taken at the edge we were called from.
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Two-phase APB write: a setup cycle, then an access cycle in which the
    // register is written because pready is always high.
    task automatic apb_write(input logic [3:0] addr, input logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [63:0] features, input logic [4:0] queues);
        wait_idle();
        apb_write(ADDR_HOST_FEATURES, features);
        apb_write(ADDR_QUEUE_COUNT, {59'd0, queues});
        cur_queue_count = queues;
        settings_used++;
    endtask

    // Every offset in the common area that has a register behind it.
    // Indexes eight and up are the ones that act on the selected queue.
    function automatic logic [7:0] mapped_offset(int idx);
        case (idx)
            0:       return OFF_DEV_FEAT_SEL;
            1:       return OFF_DEV_FEAT;
            2:       return OFF_DRV_FEAT_SEL;
            3:       return OFF_DRV_FEAT;
            4:       return OFF_CFG_VECTOR;
            5:       return OFF_NUM_QUEUES;
            6:       return OFF_STATUS;
            7:       return OFF_CFG_GEN;
            8:       return OFF_QUEUE_NOTIFY;
            9:       return OFF_QUEUE_SEL;
            10:      return OFF_QUEUE_SIZE;
            11:      return OFF_QUEUE_VECTOR;
            12:      return OFF_QUEUE_ENABLE;
            13:      return OFF_RING_0;
            14:      return OFF_RING_1;
            15:      return OFF_RING_2;
            16:      return OFF_RING_3;
            17:      return OFF_RING_4;
            default: return OFF_RING_5;
        endcase
    endfunction

    // Write values shaped to the register they land in: the selects mostly
    // hold zero or one so that the feature halves are really exercised, the
    // queue select mostly lands in range or just past it, and the enable
    // sees values whose low half is zero but whose high half is not.
    function automatic logic [31:0] value_for(logic [7:0] off);
        int roll;
        roll = $urandom_range(0, 99);
        case (off)
            OFF_DEV_FEAT_SEL, OFF_DRV_FEAT_SEL:
                return (roll < 80) ? 32'($urandom_range(0, 1)) : $urandom;
            OFF_QUEUE_SEL:
            begin
                if (roll < 80)
                    return 32'($urandom_range(0, cur_queue_count));
                if (roll < 90)
                    return 32'($urandom_range(0, QUEUE_SLOTS - 1));
                return $urandom;
            end
            OFF_QUEUE_ENABLE:
            begin
                if (roll < 30)
                    return 32'd0;
                if (roll < 60)
                    return 32'd1;
                if (roll < 80)
                    return $urandom & 32'hFFFF_0000;
                return $urandom;
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic send_common(input logic [7:0] off);
        if ($urandom_range(0, 1) == 0)
            send_item(OP_READ, off, $urandom);
        else
            send_item(OP_WRITE, off, value_for(off));
    endtask

    // One stretch of random traffic. Most of it is well-formed driver work
    // (selecting a queue then programming it, negotiating features, raising
    // and acknowledging interrupts); the rest is stray or malformed access.
    task automatic random_traffic();
        int roll;
        int runs;
        logic [7:0] off;
        roll = $urandom_range(0, 99);
        if (roll < 35)
        begin
            if ($urandom_range(0, 9) == 0)
                off = 8'($urandom_range(0, OFF_DOORBELL - 1));
            else
                off = mapped_offset($urandom_range(0, 18));
            send_common(off);
        end
        else if (roll < 55)
        begin
            send_item(OP_WRITE, OFF_QUEUE_SEL, 32'($urandom_range(0, cur_queue_count - 1)));
            runs = $urandom_range(3, 8);
            repeat (runs) send_common(mapped_offset($urandom_range(8, 18)));
        end
        else if (roll < 65)
        begin
            send_item(OP_WRITE, OFF_DRV_FEAT_SEL, value_for(OFF_DRV_FEAT_SEL));
            send_item(OP_WRITE, OFF_DRV_FEAT, $urandom);
            send_item(OP_WRITE, OFF_DEV_FEAT_SEL, value_for(OFF_DEV_FEAT_SEL));
            send_item(OP_READ, OFF_DEV_FEAT, $urandom);
        end
        else if (roll < 77)
        begin
            runs = $urandom_range(1, 2);
            repeat (runs) send_item(OP_RAISE, 8'($urandom), $urandom);
            if ($urandom_range(0, 4) != 0)
                send_item(OP_READ, OFF_ISR, $urandom);
            else
                send_item(2'($urandom_range(0, 1)), 8'($urandom_range(OFF_ISR, 63)),
                          $urandom);
        end
        else if (roll < 85)
        begin
            send_item(2'($urandom_range(0, 1)), 8'($urandom_range(OFF_DOORBELL, 63)),
                      $urandom);
        end
        else if (roll < 92)
        begin
            send_item(2'($urandom_range(0, 1)), 8'($urandom_range(OFF_DEVICE, 255)),
                      $urandom);
        end
        else if (roll < 97)
        begin
            send_item(2'($urandom_range(0, 3)), 8'($urandom), $urandom);
        end
        else
        begin
            send_item(OP_UNUSED, 8'($urandom), $urandom);
        end
    endtask

    initial
    begin
        logic [63:0] features;
        logic [4:0]  queues;
        int          phase_target;

        items_sent    = 0;
        settings_used = 0;
        gap_mode      = 1;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk over the special cases, still on the reset
        // configuration: no features offered and a single queue.
        send_item(OP_READ, OFF_DEV_FEAT, 32'd0);              // low half, version bit absent
        send_item(OP_WRITE, OFF_DEV_FEAT_SEL, 32'd1);
        send_item(OP_READ, OFF_DEV_FEAT, 32'd0);              // high half shows version bit
        send_item(OP_WRITE, OFF_DEV_FEAT_SEL, 32'hFFFF_FFFF);
        send_item(OP_READ, OFF_DEV_FEAT, 32'd0);              // select above one reads zero
        send_item(OP_WRITE, OFF_DRV_FEAT_SEL, 32'd1);
        send_item(OP_WRITE, OFF_DRV_FEAT, 32'hFFFF_FFFF);     // upper half of driver features
        send_item(OP_WRITE, OFF_DRV_FEAT_SEL, 32'd2);
        send_item(OP_WRITE, OFF_DRV_FEAT, 32'h1234_5678);     // ignored, select out of range
        send_item(OP_WRITE, OFF_STATUS, 32'hFFFF_FFFF);
        send_item(OP_WRITE, OFF_QUEUE_SEL, 32'h0000_FFFF);    // beyond the queue count: kept
        send_item(OP_READ, OFF_NUM_QUEUES, 32'd0);
        send_item(OP_WRITE, OFF_QUEUE_ENABLE, 32'hFFFF_0000); // low half zero clears
        send_item(OP_WRITE, OFF_QUEUE_ENABLE, 32'd1);
        send_item(OP_READ, OFF_QUEUE_ENABLE, 32'd0);
        send_item(OP_WRITE, OFF_RING_5, 32'hFFFF_FFFF);
        send_item(OP_READ, OFF_RING_5, 32'd0);
        send_item(OP_READ, 8'd1, 32'd0);                      // unlisted common offset
        send_item(OP_WRITE, 8'd59, 32'hFFFF_FFFF);            // doorbell at its last byte
        send_item(OP_READ, OFF_DOORBELL, 32'd0);              // doorbell has no read side
        send_item(OP_RAISE, 8'd255, 32'hFFFF_FFFF);           // offset plays no part
        send_item(OP_READ, 8'd61, 32'd0);                     // ISR read off its address
        send_item(OP_WRITE, OFF_ISR, 32'hFFFF_FFFF);          // ISR has no write side
        send_item(OP_READ, OFF_ISR, 32'd0);                   // returns, clears, lowers irq
        send_item(OP_READ, OFF_DEVICE, 32'd0);
        send_item(OP_WRITE, 8'd255, 32'hFFFF_FFFF);           // top of device space
        send_item(OP_UNUSED, 8'd0, 32'hFFFF_FFFF);

        // Random phases, each under its own configuration. The first two take
        // the extremes; phase one also runs with start held high throughout.
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0:
                begin
                    features = '1;
                    queues   = 5'd16;
                end
                1:
                begin
                    features = '0;
                    queues   = 5'd1;
                end
                2:
                begin
                    features = {$urandom, $urandom};
                    queues   = 5'd16;
                end
                3:
                begin
                    features = {$urandom, $urandom};
                    queues   = 5'd2;
                end
                default:
                begin
                    features = {$urandom, $urandom};
                    queues   = 5'($urandom_range(1, 16));
                end
            endcase
            configure(features, queues);
            gap_mode     = (phase + 2) % 3;
            phase_target = items_sent + PHASE_ITEMS;
            while (items_sent < phase_target)
                random_traffic();
        end

        wait_idle();
        $display("Run covered %0d items under %0d register settings plus reset defaults.",
                 items_sent, settings_used);
        $display("%0d results compared, %0d failures, %0d results still owed.",
                 checked_count, fail_count, outstanding);
        if (fail_count == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Guard against a stalled handshake or a result that never comes.
    initial
    begin
        #2_000_000;
        $display("Timeout: the run did not finish in the time allowed.");
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/vpcc_pkg.sv
design/virtio_pci_common_config_regs.sv
bench/tb_vpcc_pkg.sv
bench/vpcc_result_checker.sv
bench/tb_virtio_pci_common_config_regs.sv
